### src/csv_line_joystick_button_parser_macros.svh
`ifndef CSV_LINE_JOYSTICK_BUTTON_PARSER_MACROS_SVH
`define CSV_LINE_JOYSTICK_BUTTON_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CLJBP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CLJBP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cljbp_pkg.sv
package cljbp_pkg;

    localparam int DEF_LINE_CHARS = 31;
    localparam int DEF_TIME_BITS  = 32;
    localparam int NUM_BUTTONS    = 4;
    localparam int BTN_IDX_W      = $clog2(NUM_BUTTONS);
    localparam int FIELDS         = 2 + NUM_BUTTONS;
    localparam int FIELD_W        = $clog2(FIELDS + 1);
    localparam int ACC_W          = 17;
    localparam int AXIS_W         = 16;

    localparam logic [15:0]        HOLD_MS_RESET = 16'd50;
    localparam logic [ACC_W-1:0]   SAT_MAG       = ACC_W'(32768);
    localparam logic [ACC_W-1:0]   POS_MAX       = ACC_W'(32767);

    localparam logic [FIELD_W-1:0] FLD_X = FIELD_W'(0);
    localparam logic [FIELD_W-1:0] FLD_Y = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] FLD_BTN0 = FIELD_W'(2);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } cljbp_in_t;

    typedef struct packed {
        logic                     line_done;
        logic signed [AXIS_W-1:0] x_value;
        logic signed [AXIS_W-1:0] y_value;
        logic [NUM_BUTTONS-1:0]   held_mask;
        logic [NUM_BUTTONS-1:0]   pressed_mask;
        logic [NUM_BUTTONS-1:0]   released_mask;
    } cljbp_out_t;

    typedef struct packed {
        logic rx;
        logic eol;
    } cljbp_ctl_t;

    typedef struct packed {
        logic [AXIS_W-1:0]      x;
        logic [AXIS_W-1:0]      y;
        logic [1:0]             axis_ok;
        logic [NUM_BUTTONS-1:0] nonzero;
    } cljbp_line_t;

endpackage

### src/csv_line_joystick_button_parser.sv
// Joystick line parser: takes received bytes and one-millisecond ticks and reads
// newline-terminated lines "x,y,b1,b2,b3,b4" one character per item. X and Y
// update on the newline when they parsed; a button that did not parse or read
// zero counts as held. Every item, tick or byte, gives exactly one result item
// with the axes and the held, pressed and released masks. One item is taken
// per clock cycle while out_stall does not hold the result; an item passes an input
// register and then a result register, and the parse and button update sit between
// those two registers. hold_ms is written through cfg_we and cfg_data; the user must
// do so only while the block is idle, as the block itself does not enforce this.
module csv_line_joystick_button_parser
    import cljbp_pkg::*;
#(
    parameter int LINE_CHARS = DEF_LINE_CHARS,
    parameter int TIME_BITS  = DEF_TIME_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cljbp_in_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output cljbp_out_t  out_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic                   in_vld_reg, in_vld_next;
    cljbp_in_t              in_data_reg;
    logic                   out_vld_reg, out_vld_next;
    cljbp_out_t             out_data_reg, out_data_next;
    logic [15:0]            hold_reg;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [TIME_BITS-1:0]   chg_reg [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   chg_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] now_reg, now_next;
    logic [NUM_BUTTONS-1:0] before_reg, before_next;
    logic [AXIS_W-1:0]      ax_reg, ax_next;
    logic [AXIS_W-1:0]      ay_reg, ay_next;

    logic                   adv;
    logic                   accept;
    cljbp_ctl_t             ctl;
    cljbp_line_t            line;
    logic [NUM_BUTTONS-1:0] changed;
    logic [NUM_BUTTONS-1:0] aged;

    assign adv      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign ctl.eol = adv && (in_data_reg.opcode == OP_BYTE) && (in_data_reg.rx_byte == CH_LF);
    assign ctl.rx  = adv && (in_data_reg.opcode == OP_BYTE) && (in_data_reg.rx_byte != CH_LF);

    cljbp_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rx_byte (in_data_reg.rx_byte),
        .line    (line)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        time_next   = time_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        now_next    = now_reg;
        before_next = before_reg;
        chg_next    = chg_reg;
        changed     = '0;

        if (adv && (in_data_reg.opcode == OP_TICK))
        begin
            time_next = time_reg + TIME_BITS'(1);
        end

        if (ctl.eol)
        begin
            if (line.axis_ok[0])
            begin
                ax_next = line.x;
            end
            if (line.axis_ok[1])
            begin
                ay_next = line.y;
            end
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (!line.nonzero[i] != now_reg[i])
                begin
                    changed[i]     = 1'b1;
                    before_next[i] = now_reg[i];
                    now_next[i]    = !line.nonzero[i];
                    chg_next[i]    = time_reg;
                end
            end
        end

        // a button that changed on this item has zero elapsed time
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            aged[i] = !changed[i] && ((time_next - chg_reg[i]) > TIME_BITS'(hold_reg));
        end

        out_data_next.line_done     = ctl.eol;
        out_data_next.x_value       = ax_next;
        out_data_next.y_value       = ay_next;
        out_data_next.held_mask     = now_next;
        out_data_next.pressed_mask  = now_next & ~before_next & aged;
        out_data_next.released_mask = ~now_next & before_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            hold_reg    <= HOLD_MS_RESET;
            time_reg    <= '0;
            now_reg     <= '0;
            before_reg  <= '0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                chg_reg[i] <= '0;
            end
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                hold_reg <= cfg_data;
            end
            time_reg   <= time_next;
            now_reg    <= now_next;
            before_reg <= before_next;
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            chg_reg    <= chg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

### src/cljbp_parser.sv
module cljbp_parser
    import cljbp_pkg::*;
#(
    parameter int LINE_CHARS = DEF_LINE_CHARS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cljbp_ctl_t  ctl,
    input  logic [7:0]  rx_byte,
    output cljbp_line_t line
);

    localparam int CNT_W = $clog2(LINE_CHARS + 1);

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_STOP   = 4'b1000
    } cljbp_phase_t;

    cljbp_phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [FIELD_W-1:0]     field_reg, field_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [NUM_BUTTONS-1:0] raw_reg, raw_next;
    logic                   ended_reg, ended_next;
    logic [AXIS_W-1:0]      px_reg, px_next;
    logic [AXIS_W-1:0]      py_reg, py_next;
    logic [1:0]             pv_reg, pv_next;

    logic                   is_digit;
    logic                   is_space;
    logic                   last_field;
    logic [ACC_W+3:0]       prod;
    logic [AXIS_W-1:0]      cval;
    logic [FIELD_W-1:0]     bsel;
    logic                   commit;
    logic                   commit_eol;

    assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space   = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign last_field = (field_reg == FIELD_W'(FIELDS - 1));
    assign prod       = (ACC_W + 4)'(acc_reg) * (ACC_W + 4)'(10)
                      + (ACC_W + 4)'(rx_byte - CH_ZERO);
    assign cval       = neg_reg ? AXIS_W'(ACC_W'(17'h10000) - acc_reg)
                      : ((acc_reg > POS_MAX) ? AXIS_W'(POS_MAX) : acc_reg[AXIS_W-1:0]);
    assign bsel       = field_reg - FLD_BTN0;
    assign commit_eol = !ended_reg && (phase_reg == PH_DIGITS);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        field_next = field_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        raw_next   = raw_reg;
        ended_next = ended_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pv_next    = pv_reg;
        commit     = 1'b0;

        if (ctl.eol)
        begin
            phase_next = PH_SKIP;
            cnt_next   = '0;
            field_next = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            raw_next   = '0;
            ended_next = 1'b0;
            pv_next    = '0;
        end
        else if (ctl.rx && (cnt_reg < CNT_W'(LINE_CHARS)))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (!ended_reg)
            begin
                if (rx_byte == CH_NUL)
                begin
                    ended_next = 1'b1;
                    phase_next = PH_STOP;
                    commit     = (phase_reg == PH_DIGITS);
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SKIP:
                        begin
                            if (is_space)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                            begin
                                neg_next   = (rx_byte == CH_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = ACC_W'(rx_byte - CH_ZERO);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_SIGN:
                        begin
                            if (is_digit)
                            begin
                                acc_next   = ACC_W'(rx_byte - CH_ZERO);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = (prod > (ACC_W + 4)'(SAT_MAG)) ? SAT_MAG
                                         : prod[ACC_W-1:0];
                            end
                            else
                            begin
                                commit = 1'b1;
                                if (!last_field && (rx_byte == CH_COMMA))
                                begin
                                    phase_next = PH_SKIP;
                                    neg_next   = 1'b0;
                                    acc_next   = '0;
                                end
                                else
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end

        if (commit)
        begin
            case (field_reg)
                FLD_X:
                begin
                    px_next    = cval;
                    pv_next[0] = 1'b1;
                end
                FLD_Y:
                begin
                    py_next    = cval;
                    pv_next[1] = 1'b1;
                end
                default:
                begin
                    if (acc_reg != '0)
                    begin
                        raw_next[bsel[BTN_IDX_W-1:0]] = 1'b1;
                    end
                end
            endcase
            field_next = field_reg + FIELD_W'(1);
        end
    end

    // fold in a number cut off by the newline
    always_comb
    begin
        line.x       = px_reg;
        line.y       = py_reg;
        line.axis_ok = pv_reg;
        line.nonzero = raw_reg;
        if (commit_eol)
        begin
            case (field_reg)
                FLD_X:
                begin
                    line.x          = cval;
                    line.axis_ok[0] = 1'b1;
                end
                FLD_Y:
                begin
                    line.y          = cval;
                    line.axis_ok[1] = 1'b1;
                end
                default:
                begin
                    if (acc_reg != '0)
                    begin
                        line.nonzero[bsel[BTN_IDX_W-1:0]] = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            cnt_reg   <= '0;
            field_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            raw_reg   <= '0;
            ended_reg <= 1'b0;
            px_reg    <= '0;
            py_reg    <= '0;
            pv_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            field_reg <= field_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            raw_reg   <= raw_next;
            ended_reg <= ended_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

### src/cljbp_checker.sv
`include "csv_line_joystick_button_parser_macros.svh"

module cljbp_checker
    import cljbp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input cljbp_in_t  in_data,
    input logic       out_valid,
    input logic       out_stall,
    input cljbp_out_t out_data
);

    `CLJBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")
    `CLJBP_ASSERT_NOW(a_rel_not_held, out_valid, (out_data.released_mask & out_data.held_mask) == '0, "released button also held")
    `CLJBP_ASSERT_NOW(a_press_held, out_valid, (out_data.pressed_mask & ~out_data.held_mask) == '0, "pressed button not held")
    `CLJBP_ASSERT_NOW(a_press_rel, out_valid, (out_data.pressed_mask & out_data.released_mask) == '0, "button pressed and released at once")

endmodule

bind csv_line_joystick_button_parser cljbp_checker u_cljbp_checker (.*);
